### hdl/text_console_writer_assert.svh
// Assertion shorthands for the console checker. Both sample on clk and
// are disabled while rst_n is low.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tcw_pkg.sv
package tcw_pkg;

  localparam int OP_W      = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int POS_W     = 11;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_BLANK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;   // latch request, start cell read
    logic exec;      // apply request to cursor and cell store
    logic copy;      // one step of the scroll copy
    logic blank;     // one step of the blanking sweep
    logic init;      // one step of the post-reset sweep
    logic finish;    // result of a walking request goes out
    logic load_out;  // load the output register
  } cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic need_clear;
    logic copy_done;
    logic blank_done;
  } sts_t;

endpackage

### hdl/tcw_ctrl.sv
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (sts.blank_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (slot_free) begin
          if (sts.need_scroll)     state_nxt = ST_COPY;
          else if (sts.need_clear) state_nxt = ST_BLANK;
          else                     state_nxt = ST_IDLE;
        end
      end
      ST_COPY: begin
        if (sts.copy_done) state_nxt = ST_BLANK;
      end
      ST_BLANK: begin
        if (sts.blank_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_tready    = 1'b0;
    case (state_r)
      ST_INIT:   cmd.init = 1'b1;
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_EXEC: begin
        cmd.exec     = slot_free;
        cmd.load_out = slot_free && !sts.need_scroll && !sts.need_clear;
      end
      ST_COPY:   cmd.copy = 1'b1;
      ST_BLANK:  cmd.blank = 1'b1;
      ST_FINISH: begin
        cmd.finish   = slot_free;
        cmd.load_out = slot_free;
      end
      default: cmd = '0;
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && !out_tready);
  assign out_tvalid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/tcw_datapath.sv
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic [ATTR_W-1:0]    in_attribute,
  input  logic [IDX_W-1:0]     in_cell_index,
  output logic [POS_W-1:0]     out_cursor_position,
  output logic [COL_OUT_W-1:0] out_cursor_column,
  output logic [ROW_OUT_W-1:0] out_cursor_row,
  output logic                 out_scrolled,
  output logic [CHAR_W-1:0]    out_read_char,
  output logic [ATTR_W-1:0]    out_read_attribute
);

  localparam int CELLS     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int COPY_LEN  = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
  localparam int LAST_CELL = CELLS - 1;
  localparam int LAST_ROW  = SCREEN_ROWS - 1;
  localparam int COL_W     = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W     = $clog2(SCREEN_ROWS);
  localparam int CELL_W    = $clog2(CELLS);
  localparam int WORD_W    = ATTR_W + CHAR_W;

  // captured request
  logic [OP_W-1:0]   op_r;
  logic [CHAR_W-1:0] ch_r;
  logic [ATTR_W-1:0] attr_r;
  logic              in_range_r;

  // cursor, kept as column, row, row start and linear cell
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CELL_W-1:0] base_r, base_nxt;
  logic [CELL_W-1:0] pos_r, pos_nxt;

  logic [CELL_W-1:0] walk_r, walk_nxt;

  logic [WORD_W-1:0] mem_r [CELLS];
  logic [WORD_W-1:0] mem_q_r;

  logic              rd_en, we;
  logic [CELL_W-1:0] rd_addr, wa;
  logic [WORD_W-1:0] wd;

  logic              put_we;
  logic [CELL_W-1:0] put_wa;
  logic [WORD_W-1:0] put_wd;
  logic              need_scroll;
  logic              row_step;
  logic [COL_W:0]    col_inc;

  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [CELL_W-1:0] cur_pos;
  logic [31:0]       pos_wide, col_wide, row_wide;

  logic [POS_W-1:0]     pos_o_r;
  logic [COL_OUT_W-1:0] col_o_r;
  logic [ROW_OUT_W-1:0] row_o_r;
  logic                 scr_o_r;
  logic [WORD_W-1:0]    rd_o_r;

  assign col_inc = {1'b0, col_r} + 1'b1;

  // cursor move and cell write of a put, cursor reset of a clear
  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    base_nxt    = base_r;
    pos_nxt     = pos_r;
    need_scroll = 1'b0;
    row_step    = 1'b0;
    put_we      = 1'b0;
    put_wa      = pos_r;
    put_wd      = {attr_r, ch_r};
    if (op_r == OP_PUT) begin
      if (ch_r == CH_NEWLINE) begin
        row_step = 1'b1;
      end else if (ch_r == CH_BACKSPACE) begin
        if (col_r != '0) begin
          col_nxt = col_r - 1'b1;
          pos_nxt = pos_r - 1'b1;
          put_we  = 1'b1;
          put_wa  = pos_r - 1'b1;
          put_wd  = {attr_r, CH_SPACE};
        end
      end else begin
        put_we = 1'b1;
        if (col_inc == (COL_W+1)'(SCREEN_COLUMNS)) begin
          row_step = 1'b1;
        end else begin
          col_nxt = col_inc[COL_W-1:0];
          pos_nxt = pos_r + 1'b1;
        end
      end
      if (row_step) begin
        col_nxt = '0;
        if (row_r == ROW_W'(LAST_ROW)) begin
          need_scroll = 1'b1;
          pos_nxt     = base_r;
        end else begin
          row_nxt  = row_r + 1'b1;
          base_nxt = base_r + CELL_W'(SCREEN_COLUMNS);
          pos_nxt  = base_nxt;
        end
      end
    end else if (op_r == OP_CLEAR) begin
      col_nxt  = '0;
      row_nxt  = '0;
      base_nxt = '0;
      pos_nxt  = '0;
    end
  end

  assign sts.need_scroll = need_scroll;
  assign sts.need_clear  = (op_r == OP_CLEAR);
  assign sts.copy_done   = (walk_r == CELL_W'(COPY_LEN));
  assign sts.blank_done  = (walk_r == CELL_W'(LAST_CELL));

  // cell store port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = CELL_W'(in_cell_index);
    we      = 1'b0;
    wa      = walk_r;
    wd      = {attr_r, CH_SPACE};
    if (cmd.capture) begin
      rd_en = 1'b1;
    end
    if (cmd.exec) begin
      we = put_we;
      wa = put_wa;
      wd = put_wd;
    end
    if (cmd.copy) begin
      // read one row ahead, write the word fetched last cycle
      if (!sts.copy_done) begin
        rd_en   = 1'b1;
        rd_addr = walk_r + CELL_W'(SCREEN_COLUMNS);
      end
      if (walk_r != '0) begin
        we = 1'b1;
        wa = walk_r - 1'b1;
        wd = mem_q_r;
      end
    end
    if (cmd.blank || cmd.init) begin
      we = 1'b1;
      wa = walk_r;
      wd = {(cmd.init ? RESET_ATTR : attr_r), CH_SPACE};
    end
  end

  always_comb begin
    walk_nxt = walk_r;
    if (cmd.exec) begin
      walk_nxt = '0;
    end else if (cmd.copy && !sts.copy_done) begin
      walk_nxt = walk_r + 1'b1;
    end else if ((cmd.blank || cmd.init) && !sts.blank_done) begin
      walk_nxt = walk_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem_r[wa] <= wd;
    if (rd_en) mem_q_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      base_r <= '0;
      pos_r  <= '0;
      walk_r <= '0;
    end else begin
      walk_r <= walk_nxt;
      if (cmd.exec) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        base_r <= base_nxt;
        pos_r  <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_operation;
      ch_r       <= in_char_code;
      attr_r     <= in_attribute;
      in_range_r <= (32'(in_cell_index) < CELLS);
    end
  end

  // exec loads the freshly moved cursor, finish the stored one
  assign cur_col  = cmd.exec ? col_nxt : col_r;
  assign cur_row  = cmd.exec ? row_nxt : row_r;
  assign cur_pos  = cmd.exec ? pos_nxt : pos_r;
  assign pos_wide = 32'(cur_pos);
  assign col_wide = 32'(cur_col);
  assign row_wide = 32'(cur_row);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pos_o_r <= pos_wide[POS_W-1:0];
      col_o_r <= col_wide[COL_OUT_W-1:0];
      row_o_r <= row_wide[ROW_OUT_W-1:0];
      scr_o_r <= cmd.finish && (op_r == OP_PUT);
      rd_o_r  <= (op_r == OP_READ && in_range_r) ? mem_q_r : '0;
    end
  end

  assign out_cursor_position = pos_o_r;
  assign out_cursor_column   = col_o_r;
  assign out_cursor_row      = row_o_r;
  assign out_scrolled        = scr_o_r;
  assign out_read_char       = rd_o_r[CHAR_W-1:0];
  assign out_read_attribute  = rd_o_r[WORD_W-1:CHAR_W];

endmodule

### hdl/text_console_writer.sv
// Character-cell text console with a SCREEN_COLUMNS x SCREEN_ROWS cell store.
// Request channel (in_*): in_tuser carries the operation (put, clear, read),
// in_tdata the character, attribute and cell number to read back.
// Result channel (out_*): one result per request with the linear cursor,
// column, row, a scrolled flag and the character/attribute of a read.
// Put (no scroll), read and unused codes: the request is captured with a
// registered read of the cell store, then the update step, once the output slot
// is free, applies it and loads the result; no new request is taken until idle.
// Put that scrolls: the copy moves one cell per cycle through the store, then the
// bottom row is blanked and the finish step loads the result.
// Clear: every cell is blanked, one cell per cycle, before the result is loaded.
// After reset the store is swept to space/attribute 0x07, one cell per cycle;
// in_tready stays low meanwhile.
// Results sit in an output register: a new request is taken while a result
// waits, and the next result is held back until out_tready frees the slot.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char_code[7:0], attribute[15:8], cell_index[26:16]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // cursor_position[10:0], cursor_column[17:11],
                                  // cursor_row[22:18], scrolled[23],
                                  // read_char[31:24], read_attribute[39:32]
);

  cmd_t cmd;
  sts_t sts;

  logic [POS_W-1:0]     res_pos;
  logic [COL_OUT_W-1:0] res_col;
  logic [ROW_OUT_W-1:0] res_row;
  logic                 res_scr;
  logic [CHAR_W-1:0]    res_char;
  logic [ATTR_W-1:0]    res_attr;

  tcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tcw_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_operation        (in_tuser),
    .in_char_code        (in_tdata[7:0]),
    .in_attribute        (in_tdata[15:8]),
    .in_cell_index       (in_tdata[26:16]),
    .out_cursor_position (res_pos),
    .out_cursor_column   (res_col),
    .out_cursor_row      (res_row),
    .out_scrolled        (res_scr),
    .out_read_char       (res_char),
    .out_read_attribute  (res_attr)
  );

  assign out_tdata = {res_attr, res_char, res_scr, res_row, res_col, res_pos};

endmodule

### hdl/tcw_checker.sv
`include "text_console_writer_assert.svh"

module tcw_checker #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  localparam int   CELLS    = SCREEN_COLUMNS * SCREEN_ROWS;
  // position check only where the reported position and row fields are not truncated
  localparam logic POS_OK   = (CELLS <= 2048) && (SCREEN_ROWS <= 32);
  localparam logic [4:0] LAST_ROW5 = 5'(SCREEN_ROWS - 1);

  logic [10:0] res_pos;
  logic [6:0]  res_col;
  logic [4:0]  res_row;
  logic        res_scr;
  logic [15:0] res_rd;
  logic [31:0] pos_calc;
  logic        scroll_ok;
  logic        pos_same;

  assign res_pos   = out_tdata[10:0];
  assign res_col   = out_tdata[17:11];
  assign res_row   = out_tdata[22:18];
  assign res_scr   = out_tdata[23];
  assign res_rd    = out_tdata[39:24];
  assign pos_calc  = 32'(res_row) * 32'(SCREEN_COLUMNS) + 32'(res_col);
  assign scroll_ok = (res_col == 7'd0) && (res_row == LAST_ROW5) && (res_rd == 16'd0);
  assign pos_same  = (res_pos == pos_calc[10:0]);

  `TCW_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  `TCW_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed")
  `TCW_ASSERT_IMP(a_scroll_cursor, out_tvalid && res_scr, scroll_ok, "scroll cursor wrong")
  `TCW_ASSERT_IMP(a_pos_match, out_tvalid && POS_OK, pos_same, "cursor position mismatch")
  // one request at a time: ready drops right after an accept
  `TCW_ASSERT_NXT(a_in_single, in_tvalid && in_tready, !in_tready, "back-to-back accept")

endmodule

bind text_console_writer tcw_checker #(
  .SCREEN_COLUMNS (SCREEN_COLUMNS),
  .SCREEN_ROWS    (SCREEN_ROWS)
) u_tcw_checker (.*);

### sim/console_result_checker.sv
module console_result_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [POS_W-1:0]     cursor_pos;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic                 scrolled;
    logic [CHAR_W-1:0]    rd_char;
    logic [ATTR_W-1:0]    rd_attr;
  } console_result_t;

  // attribute in the high byte, character in the low byte
  logic [15:0]     screen [CELLS];
  int              col_now;
  int              row_now;
  console_result_t expected_q [$];

  function automatic void blank_cells(int first, int last, logic [ATTR_W-1:0] attr);
    for (int i = first; i < last; i++) screen[i] = {attr, CH_SPACE};
  endfunction

  function automatic console_result_t apply_request(logic [OP_W-1:0] op,
                                                    logic [CHAR_W-1:0] ch,
                                                    logic [ATTR_W-1:0] attr,
                                                    logic [IDX_W-1:0] idx);
    console_result_t r;
    r = '0;
    case (op)
      OP_PUT: begin
        if (ch == CH_NEWLINE) begin
          col_now = 0;
          row_now++;
        end else if (ch == CH_BACKSPACE) begin
          if (col_now > 0) begin
            col_now--;
            screen[row_now * COLUMNS + col_now] = {attr, CH_SPACE};
          end
        end else begin
          screen[row_now * COLUMNS + col_now] = {attr, ch};
          col_now++;
        end
        if (col_now >= COLUMNS) begin
          col_now = 0;
          row_now++;
        end
        // fell off the bottom: shift everything up a row, blank the last one
        if (row_now >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          blank_cells(CELLS - COLUMNS, CELLS, attr);
          row_now    = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      OP_CLEAR: begin
        blank_cells(0, CELLS, attr);
        col_now = 0;
        row_now = 0;
      end
      OP_READ: begin
        if (idx < CELLS) begin
          r.rd_char = screen[idx][7:0];
          r.rd_attr = screen[idx][15:8];
        end
      end
      default: ;
    endcase
    r.cursor_pos = POS_W'(row_now * COLUMNS + col_now);
    r.cursor_col = COL_OUT_W'(col_now);
    r.cursor_row = ROW_OUT_W'(row_now);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    console_result_t want;
    if (!rst_n) begin
      blank_cells(0, CELLS, RESET_ATTR);
      col_now = 0;
      row_now = 0;
      expected_q.delete();
      fail_count = 0;
      results_pending <= 0;
    end else begin
      // retire first: a result can never belong to a request taken this edge
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: %h", out_tdata);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("cursor_position", want.cursor_pos, out_tdata[10:0]);
          check_field("cursor_column", want.cursor_col, out_tdata[17:11]);
          check_field("cursor_row", want.cursor_row, out_tdata[22:18]);
          check_field("scrolled", want.scrolled, out_tdata[23]);
          check_field("read_char", want.rd_char, out_tdata[31:24]);
          check_field("read_attribute", want.rd_attr, out_tdata[39:32]);
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(apply_request(in_tuser, in_tdata[7:0], in_tdata[15:8],
                                           in_tdata[26:16]));
      results_pending <= expected_q.size();
    end
  end

endmodule

### sim/text_console_writer_tb.sv
module text_console_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // unused code, block must ignore it

  localparam int REQUEST_GOAL = 2000;
  localparam int STALL_AT     = 600;
  localparam int STALL_CYCLES = 400;
  localparam int DRAIN_LIMIT  = 100000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  logic        sink_hold = 1'b0;
  int          requests_sent = 0;
  int unsigned tx_burst_left = 0;
  int unsigned rx_burst_left = 0;
  int          fail_count;
  int          results_pending;

  always #2 clk = ~clk;

  text_console_writer #(
    .SCREEN_COLUMNS(COLUMNS),
    .SCREEN_ROWS   (ROWS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  console_result_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .fail_count     (fail_count),
    .results_pending(results_pending)
  );

  // mostly printable text, now and then any byte at all
  function automatic logic [CHAR_W-1:0] text_byte();
    if ($urandom_range(0, 3) == 0) return CHAR_W'($urandom);
    return CHAR_W'($urandom_range(32, 126));
  endfunction

  // bias reads toward the bottom row, where scroll blanking lands
  function automatic logic [IDX_W-1:0] read_index();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
    if (pick < 4) return IDX_W'($urandom_range(CELLS - COLUMNS, CELLS - 1));
    return IDX_W'($urandom_range(0, CELLS - 1));
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [ATTR_W-1:0] attr, input logic [IDX_W-1:0] idx);
    int unsigned gap;
    if (tx_burst_left > 0) begin
      gap = 0;
      tx_burst_left--;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 39) == 0) tx_burst_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'd0, idx, attr, ch};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  initial begin : stimulus
    int unsigned kind;
    logic [ATTR_W-1:0] attr;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_PUT;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset contents, range edges of a read, out-of-range reads
    send_request(OP_READ, 8'h00, 8'h00, 11'd0);
    send_request(OP_READ, 8'hFF, 8'hFF, IDX_W'(CELLS - 1));
    send_request(OP_READ, 8'h00, 8'h00, IDX_W'(CELLS));
    send_request(OP_READ, 8'hFF, 8'hFF, 11'h7FF);
    // backspace at column 0 does nothing
    send_request(OP_PUT, CH_BACKSPACE, 8'h5A, 11'd0);
    send_request(OP_PUT, 8'h00, 8'h00, 11'h7FF);
    send_request(OP_PUT, 8'hFF, 8'hFF, 11'd0);
    // backspace blanks the cell it steps onto
    send_request(OP_PUT, CH_BACKSPACE, 8'h3C, 11'h555);
    send_request(OP_READ, 8'h00, 8'h00, 11'd0);
    send_request(OP_READ, 8'h00, 8'h00, 11'd1);
    send_request(OP_SPARE, 8'hFF, 8'hFF, 11'h7FF);
    send_request(OP_PUT, CH_NEWLINE, 8'h11, 11'h2AA);
    send_request(OP_PUT, 8'h41, 8'h1F, 11'd0);
    send_request(OP_READ, 8'h00, 8'h00, IDX_W'(COLUMNS));
    send_request(OP_CLEAR, 8'hAA, 8'hA5, 11'h7FF);
    send_request(OP_READ, 8'h00, 8'h00, IDX_W'(CELLS - 1));
    send_request(OP_READ, 8'h00, 8'h00, IDX_W'(COLUMNS));
    send_request(OP_SPARE, 8'h00, 8'h00, 11'd0);
    send_request(OP_PUT, 8'h7E, 8'h42, 11'd0);
    send_request(OP_CLEAR, 8'h00, 8'h00, 11'd0);
    send_request(OP_READ, 8'h00, 8'h00, 11'd0);
    send_request(OP_CLEAR, 8'hFF, 8'hFF, 11'd0);
    send_request(OP_READ, 8'hFF, 8'hFF, IDX_W'(CELLS - 1));

    while (requests_sent < REQUEST_GOAL) begin
      kind = $urandom_range(0, 99);
      attr = ATTR_W'($urandom);
      if (kind < 40) begin
        // one line of text, usually closed by a newline
        repeat ($urandom_range(1, 60)) send_request(OP_PUT, text_byte(), attr, IDX_W'($urandom));
        if ($urandom_range(0, 9) < 7) send_request(OP_PUT, CH_NEWLINE, attr, IDX_W'($urandom));
      end else if (kind < 55) begin
        repeat ($urandom_range(1, 8))
          send_request(OP_READ, CHAR_W'($urandom), ATTR_W'($urandom), read_index());
      end else if (kind < 65) begin
        // backspaces often run past column 0
        repeat ($urandom_range(1, 6)) send_request(OP_PUT, text_byte(), attr, IDX_W'($urandom));
        repeat ($urandom_range(1, 10)) send_request(OP_PUT, CH_BACKSPACE, attr, IDX_W'($urandom));
      end else if (kind < 73) begin
        repeat ($urandom_range(1, 12)) send_request(OP_PUT, CH_NEWLINE, attr, IDX_W'($urandom));
      end else if (kind < 75) begin
        send_request(OP_CLEAR, CHAR_W'($urandom), attr, IDX_W'($urandom));
      end else if (kind < 80) begin
        // long run that wraps across row ends
        repeat ($urandom_range(70, 170)) send_request(OP_PUT, text_byte(), attr, IDX_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 4))
          send_request(OP_W'($urandom_range(OP_PUT, OP_SPARE)), CHAR_W'($urandom),
                       ATTR_W'($urandom), IDX_W'($urandom_range(0, (1 << IDX_W) - 1)));
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < DRAIN_LIMIT && results_pending != 0; k++) @(posedge clk);
    repeat (50) @(posedge clk);
    if (results_pending != 0) $error("%0d results never arrived", results_pending);
    if (fail_count == 0 && results_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned pause;
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_burst_left > 0) begin
        pause = 0;
        rx_burst_left--;
      end else begin
        pause = $urandom_range(0, 5);
        if ($urandom_range(0, 39) == 0) rx_burst_left = $urandom_range(20, 60);
      end
      if (pause > 0 || sink_hold) begin
        out_tready <= 1'b0;
        repeat (pause) @(posedge clk);
        while (sink_hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // long hold-off on the result side so the block backs up into in_tready
  initial begin : sink_stall
    wait (requests_sent >= STALL_AT);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin : watchdog
    #100ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
